[hw/rtl/tso_pkg.sv]
// Shared types, register codes and sine table arithmetic for the triggered sine oscillator.
`timescale 1ns / 1ps
`default_nettype none

package tso_pkg;

  // Default build parameters.
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;

  // Register file layout.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WRAP_LIMIT      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RECYCLE_MODE    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ZERO_ON_TRIGGER = 2'd2;

  // One turn is 65536 phase units (360 degrees), so the wrap limit resets to one turn.
  localparam int TURN_BITS = 16;
  localparam logic [31:0] WRAP_LIMIT_RESET = 32'd65536;

  // Field widths.
  localparam int STEP_BITS   = 24;
  localparam int SAMPLE_OUT_BITS = 16;

  // Quarter turn in Q2.30.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Result of the phase stage, handed to the lookup and output stage.
  typedef struct packed {
    logic                 upd;      // the sample is recomputed for this item
    logic                 playing;  // playback state after this item
    logic [TURN_BITS-1:0] phase;    // phase modulo one turn
  } tso_res_t;

  // Sine of x (Q2.30) by a Taylor series up to the x^15 term, each term truncated.
  function automatic logic [31:0] tso_sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd210;
    acc  = acc - term;
    return acc[31:0];
  endfunction

  // Quarter-wave table entry i, rounded to the full-scale amplitude and clamped.
  function automatic logic [31:0] tso_sine_entry(input int addr_bits, input int sample_bits,
                                                 input int i);
    logic [63:0] amp;
    logic [63:0] x;
    logic [63:0] v;
    amp = (64'd1 << (sample_bits - 1)) - 64'd1;
    x   = (HALF_PI_Q30 * 64'(i)) >> addr_bits;
    v   = ({32'd0, tso_sine_q30(x)} * amp + (64'd1 << 29)) >> 30;
    if (v > amp) begin
      v = amp;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tso_phase_acc.sv]
// Input register and phase accumulator stage with the playback state.
`timescale 1ns / 1ps
`default_nettype none

module tso_phase_acc (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_trigger,
  input  wire logic [tso_pkg::STEP_BITS-1:0] in_step,
  input  wire logic [31:0]                   lim,
  input  wire logic                          recycle,
  input  wire logic                          zero_on_trig,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output tso_pkg::tso_res_t                  res
);
  import tso_pkg::*;

  // Input stage registers.
  logic                 a_valid;
  logic                 a_trigger;
  logic [STEP_BITS-1:0] a_step;
  logic [31:0]          a_lim_ms;

  // Phase state.
  logic [31:0] phase;
  logic        active;

  logic        rdy_a;
  logic        rdy_b;
  logic        step_gt;
  logic [STEP_BITS-1:0] step_c;
  logic [31:0] lim_ms;
  logic [31:0] base;
  logic        act0;
  logic [32:0] sum;
  logic [32:0] diff;
  logic        ge1;
  logic        ge2;
  logic [31:0] phase_next;
  logic        stop;
  logic        active_next;

  // Ready ripples back from the output side; an empty stage always takes an item.
  assign rdy_b    = !out_valid || out_ready;
  assign rdy_a    = !a_valid || rdy_b;
  assign in_ready = rdy_a;

  // Clamp the step to the wrap limit and precompute the room left before a wrap.
  always_comb begin
    step_gt = {8'd0, in_step} > lim;
    step_c  = step_gt ? lim[STEP_BITS-1:0] : in_step;
    lim_ms  = step_gt ? 32'd0 : lim - {8'd0, in_step};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (rdy_a) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy_a) begin
      a_trigger <= in_trigger;
      a_step    <= step_c;
      a_lim_ms  <= lim_ms;
    end
  end

  // Advance the phase, wrap once, and decide whether one-shot playback ends.
  always_comb begin
    act0 = active || a_trigger;
    base = (a_trigger && zero_on_trig) ? 32'd0 : phase;
    sum  = {1'b0, base} + {9'd0, a_step};
    diff = sum - {1'b0, lim};
    ge1  = sum >= {1'b0, lim};
    ge2  = {1'b0, sum} >= {1'b0, lim, 1'b0};
    if (ge2) begin
      phase_next = 32'd0;
    end else if (ge1) begin
      phase_next = diff[31:0];
    end else begin
      phase_next = sum[31:0];
    end
    stop        = act0 && !recycle && (phase_next >= a_lim_ms);
    active_next = act0 && !stop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 32'd0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_b) begin
        out_valid <= a_valid;
      end
      if (a_valid && rdy_b) begin
        phase  <= phase_next;
        active <= active_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && rdy_b) begin
      res.upd     <= act0;
      res.playing <= active_next;
      res.phase   <= phase_next[TURN_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tso_sine_lut.sv]
// Quarter-wave sine table with quadrant mirroring and a registered read.
`timescale 1ns / 1ps
`default_nettype none

module tso_sine_lut #(
  parameter int TABLE_ADDR_BITS = tso_pkg::TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = tso_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic [tso_pkg::TURN_BITS-1:0] phase,
  output logic      [SAMPLE_BITS-2:0]        mag
);
  import tso_pkg::*;

  localparam int DEPTH = (1 << TABLE_ADDR_BITS) + 1;
  localparam int MAG_W = SAMPLE_BITS - 1;

  // Table contents are worked out at elaboration.
  function automatic logic [DEPTH*MAG_W-1:0] build_tab();
    logic [DEPTH*MAG_W-1:0] tab;
    tab = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tab[i*MAG_W +: MAG_W] = MAG_W'(tso_sine_entry(TABLE_ADDR_BITS, SAMPLE_BITS, i));
    end
    return tab;
  endfunction

  localparam logic [DEPTH*MAG_W-1:0] SINE_TAB = build_tab();

  logic [TABLE_ADDR_BITS-1:0] fine;
  logic [TABLE_ADDR_BITS:0]   idx;

  // The top two bits pick the quadrant; odd quadrants read the table backward.
  always_comb begin
    fine = phase[TURN_BITS-3 -: TABLE_ADDR_BITS];
    if (phase[TURN_BITS-2]) begin
      idx = (TABLE_ADDR_BITS + 1)'(1 << TABLE_ADDR_BITS) - {1'b0, fine};
    end else begin
      idx = {1'b0, fine};
    end
  end

  // The read register keeps the last magnitude while no new sample is made.
  always_ff @(posedge clk) begin
    if (rst) begin
      mag <= '0;
    end else if (en) begin
      mag <= SINE_TAB[idx*MAG_W +: MAG_W];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/triggered_sine_oscillator.sv]
// Top level of the triggered sine oscillator: registers, output stage and handshakes.
//
//  Channel | Direction | Handshake          | Payload
//  s_*     | in        | s_tvalid/s_tready  | tdata: trigger, phase_step
//  m_*     | out       | m_tvalid/m_tready  | tdata: sample, playing
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle is sustained while m_tready allows; a result passes through the input
// register, the phase accumulator register and the table read register on its way out.
// The recurrence is the phase add, wrap and compare in the accumulator stage.
// Synchronous reset stops playback, zeroes the phase and the held sample, and loads the
// register defaults; no clearing pass is needed.
// A stalled output fills the three stages before s_tready falls.
`timescale 1ns / 1ps
`default_nettype none

module triggered_sine_oscillator #(
  parameter int TABLE_ADDR_BITS = tso_pkg::TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = tso_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [31:0]                        s_tdata,   // [0] trigger, [24:1] phase_step
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [23:0]                        m_tdata,   // [15:0] sample, [16] playing
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tso_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [tso_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import tso_pkg::*;

  localparam int MAG_W = SAMPLE_BITS - 1;

  // Configuration registers.
  logic [31:0] wrap_limit;
  logic        recycle_mode;
  logic        zero_on_trigger;
  logic [31:0] lim;

  // Stage interconnect and output stage.
  logic             b_valid;
  tso_res_t         b_res;
  logic             rdy_c;
  logic             move_bc;
  logic             c_valid;
  logic             playing;
  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [14:0]      mag15;
  logic [15:0]      sample;

  assign cfg_ready = 1'b1;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_limit      <= WRAP_LIMIT_RESET;
      recycle_mode    <= 1'b0;
      zero_on_trigger <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WRAP_LIMIT:      wrap_limit      <= cfg_data[31:0];
        CFG_RECYCLE_MODE:    recycle_mode    <= cfg_data[0];
        CFG_ZERO_ON_TRIGGER: zero_on_trigger <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // A zero wrap limit behaves as one unit.
  assign lim = (wrap_limit == 32'd0) ? 32'd1 : wrap_limit;

  tso_phase_acc u_acc (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_trigger   (s_tdata[0]),
    .in_step      (s_tdata[STEP_BITS:1]),
    .lim          (lim),
    .recycle      (recycle_mode),
    .zero_on_trig (zero_on_trigger),
    .out_valid    (b_valid),
    .out_ready    (rdy_c),
    .res          (b_res)
  );

  assign rdy_c   = !c_valid || m_tready;
  assign move_bc = b_valid && rdy_c;

  tso_sine_lut #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_lut (
    .clk   (clk),
    .rst   (rst),
    .en    (move_bc && b_res.upd),
    .phase (b_res.phase),
    .mag   (mag)
  );

  // Output stage; the sign is taken only with a new sample so the last one is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      playing <= 1'b0;
      neg     <= 1'b0;
    end else begin
      if (rdy_c) begin
        c_valid <= b_valid;
      end
      if (move_bc) begin
        playing <= b_res.playing;
        if (b_res.upd) begin
          neg <= b_res.phase[TURN_BITS-1];
        end
      end
    end
  end

  // Align the table magnitude to Q1.15: a truncating right shift, or zero fill for narrow samples.
  if (SAMPLE_BITS >= 16) begin : g_align_right
    assign mag15 = 15'(mag >> (SAMPLE_BITS - 16));
  end else begin : g_align_left
    assign mag15 = {mag, {(16 - SAMPLE_BITS){1'b0}}};
  end

  assign sample   = neg ? (16'd0 - {1'b0, mag15}) : {1'b0, mag15};
  assign m_tvalid = c_valid;
  assign m_tdata  = {7'd0, playing, sample};

`ifndef SYNTHESIS
  // Input back-pressure only appears once every stage holds an item.
  a_full_before_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (b_valid && c_valid))
    else $error("input stalled while a stage was empty");

  // Playback can only be on for an item whose sample was recomputed.
  a_playing_updates: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_res.playing) |-> b_res.upd)
    else $error("playing item without a sample update");

  // A stopped item leaves the held sample untouched.
  a_hold_sample: assert property (@(posedge clk) disable iff (rst)
    (move_bc && !b_res.upd) |=> ($stable(mag) && $stable(neg)))
    else $error("held sample changed while stopped");

  // The output never reaches negative full scale.
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (sample != 16'h8000))
    else $error("sample out of Q1.15 range");
`endif

endmodule

`default_nettype wire

[dv/tb_triggered_sine_oscillator.sv]
// Self-checking testbench for the triggered sine oscillator with random stalls on both streams.
`timescale 1ns / 1ps

module tb_triggered_sine_oscillator;
  import tso_pkg::*;

  localparam int ADDR_BITS    = TABLE_ADDR_BITS_DEF;
  localparam int SMP_BITS     = SAMPLE_BITS_DEF;
  localparam int QUARTER_LEN  = (1 << ADDR_BITS) + 1;
  localparam int PHASE_ITEMS  = 130;
  localparam int NUM_PHASES   = 10;
  localparam int N_DIRECTED   = 20;
  localparam int MAX_REPORTS  = 10;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

  // One expected output tick.
  typedef struct packed {
    logic [15:0] sample;
    logic        playing;
  } tone_t;

  // Predicts the oscillator output per accepted tick and checks what comes out.
  class tone_scoreboard;
    logic [31:0] quarter_wave [QUARTER_LEN];
    logic [31:0] wrap_limit;
    logic        recycle;
    logic        zero_on_trig;
    logic [31:0] phase;
    logic        active;
    logic [15:0] held;
    tone_t       expected_tones [$];
    int          mismatches;

    function new();
      logic [63:0] amp;
      logic [63:0] x;
      logic [63:0] v;
      amp = (64'd1 << (SMP_BITS - 1)) - 64'd1;
      // Quarter-wave table, rounded to full scale and clamped.
      for (int i = 0; i < QUARTER_LEN; i++) begin
        x = (HALF_PI_Q30 * 64'(i)) >> ADDR_BITS;
        v = ({32'd0, series_sine(x)} * amp + (64'd1 << 29)) >> 30;
        if (v > amp) begin
          v = amp;
        end
        quarter_wave[i] = v[31:0];
      end
      wrap_limit   = WRAP_LIMIT_RESET;
      recycle      = 1'b0;
      zero_on_trig = 1'b0;
      phase        = '0;
      active       = 1'b0;
      held         = '0;
      mismatches   = 0;
    endfunction

    // Sine in Q2.30 by a truncated Taylor series through the x^15 term.
    function logic [31:0] series_sine(logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        acc  = (k % 2 == 1) ? acc - term : acc + term;
      end
      return acc[31:0];
    endfunction

    // Table lookup on the phase modulo one turn, with quadrant mirroring and sign.
    function logic [15:0] tone_at(logic [31:0] ph);
      logic [1:0]         quad;
      logic [ADDR_BITS:0] idx;
      logic [31:0]        mag;
      quad = ph[15:14];
      idx  = {1'b0, ph[13 -: ADDR_BITS]};
      if (quad[0]) begin
        idx = (ADDR_BITS + 1)'((1 << ADDR_BITS) - int'(idx));
      end
      mag = quarter_wave[idx];
      if (SMP_BITS > 16) begin
        mag = mag >> (SMP_BITS - 16);
      end else begin
        mag = mag << (16 - SMP_BITS);
      end
      return quad[1] ? 16'(32'd0 - mag) : mag[15:0];
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_WRAP_LIMIT:      wrap_limit   = data;
        CFG_RECYCLE_MODE:    recycle      = data[0];
        CFG_ZERO_ON_TRIGGER: zero_on_trig = data[0];
        default: ;
      endcase
    endfunction

    // Advance the phase for one accepted tick and queue the expected output.
    function void take_tick(logic trig, logic [23:0] step_in);
      logic [32:0] lim;
      logic [32:0] stp;
      logic [32:0] p;
      lim = (wrap_limit == 0) ? 33'd1 : {1'b0, wrap_limit};
      stp = {9'd0, step_in};
      if (stp > lim) begin
        stp = lim;
      end
      if (trig) begin
        active = 1'b1;
        if (zero_on_trig) begin
          phase = '0;
        end
      end
      p = {1'b0, phase} + stp;
      if (p >= lim) begin
        p = p - lim;
      end
      // A phase left above a lowered limit restarts from zero.
      if (p >= lim) begin
        p = '0;
      end
      phase = p[31:0];
      if (active) begin
        // One-shot playback ends on the tick before a wrap; that tick still plays.
        if (p + stp >= lim && !recycle) begin
          active = 1'b0;
        end
        held = tone_at(phase);
      end
      expected_tones.push_back('{sample: held, playing: active});
    endfunction

    function void check_tone(logic [15:0] smp, logic pl);
      tone_t want;
      if (expected_tones.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected output transfer: sample %0d playing %0b", $signed(smp), pl);
        end
        return;
      end
      want = expected_tones.pop_front();
      if (want.sample !== smp || want.playing !== pl) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("output mismatch at %0t: sample exp %0d got %0d, playing exp %0b got %0b",
                   $realtime, $signed(want.sample), $signed(smp), want.playing, pl);
        end
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [31:0]               s_tdata;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [23:0]               m_tdata;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      steady = 1'b0;

  tone_scoreboard sb = new();

  // Directed ticks, {phase_step, trigger}.
  logic [24:0] directed_ticks [N_DIRECTED] = '{
    {24'd0, 1'b0}, {24'd0, 1'b1}, {24'd16384, 1'b0}, {24'd16384, 1'b0},
    {24'd16384, 1'b0}, {24'd16384, 1'b0}, {24'd4096, 1'b0}, {24'd20000, 1'b0},
    {24'hFFFFFF, 1'b0}, {24'd100, 1'b0}, {24'h800000, 1'b1}, {24'h00ABCD, 1'b1},
    {24'h00ABCD, 1'b0}, {24'd1, 1'b1}, {24'd1, 1'b0}, {24'h007FFF, 1'b0},
    {24'h00FFFF, 1'b1}, {24'h010000, 1'b0}, {24'h000001, 1'b1}, {24'd0, 1'b0}
  };

  // Wrap limits per phase; the last phase draws its own.
  logic [31:0] wrap_plan [NUM_PHASES] = '{
    32'd65536, 32'd32768, 32'd208953, 32'd1000, 32'hFFFFFFFF,
    32'd1000, 32'd0, 32'd1, 32'd196608, 32'd100000
  };

  triggered_sine_oscillator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: check each transfer and stall at random.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_tone(m_tdata[15:0], m_tdata[16]);
    end
    m_tready <= steady || ($urandom_range(99) >= 35);
  end

  // Send one tick, with an optional random gap before it.
  task automatic send_item(input logic trig, input logic [23:0] step);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 35) begin
        gap++;
      end
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, step, trig};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_tick(trig, step);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Write all registers in random order; one-bit registers get noise in the upper bits.
  task automatic program_phase(input int ph);
    logic [CFG_INDEX_BITS-1:0] order [3];
    logic [CFG_INDEX_BITS-1:0] tmp;
    logic [31:0]               wrap;
    int                        j;
    order = '{CFG_WRAP_LIMIT, CFG_RECYCLE_MODE, CFG_ZERO_ON_TRIGGER};
    for (int i = 2; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    wrap = (ph == NUM_PHASES - 1) ? $urandom : wrap_plan[ph];
    if (ph == 0) begin
      write_reg(CFG_UNUSED_INDEX, $urandom);
    end
    foreach (order[i]) begin
      case (order[i])
        CFG_WRAP_LIMIT:   write_reg(order[i], wrap);
        CFG_RECYCLE_MODE: write_reg(order[i], ($urandom & 32'hFFFF_FFFE) | 32'(ph[0]));
        default:          write_reg(order[i], ($urandom & 32'hFFFF_FFFE) | 32'(ph[1]));
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly steps that play for a while, plus zero, full-scale and near-limit steps.
  function automatic logic [23:0] pick_step();
    logic [32:0] lim;
    logic [32:0] s;
    int          r;
    lim = (sb.wrap_limit == 0) ? 33'd1 : {1'b0, sb.wrap_limit};
    r   = $urandom_range(99);
    if (r < 8) begin
      s = '0;
    end else if (r < 13) begin
      s = 33'hFFFFFF;
    end else if (r < 30) begin
      s = 33'($urandom & 32'hFFFFFF);
    end else if (r < 40) begin
      s = lim + $urandom_range(4) - 2;
    end else begin
      s = (lim >> $urandom_range(7, 3)) + $urandom_range(3);
    end
    if (s > 33'hFFFFFF) begin
      s = 33'hFFFFFF;
    end
    return s[23:0];
  endfunction

  // Triggers are frequent while stopped and rare during playback.
  function automatic logic pick_trigger();
    return sb.active ? ($urandom_range(99) < 3) : ($urandom_range(99) < 25);
  endfunction

  // Wait for every expected output, then let the pipeline go quiet.
  task automatic settle();
    while (sb.expected_tones.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Main sequence: reset, directed ticks, then one random phase per register setting.
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_ticks[i]) begin
      send_item(directed_ticks[i][0], directed_ticks[i][24:1]);
    end
    s_tvalid <= 1'b0;
    settle();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      program_phase(ph);
      steady <= (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(pick_trigger(), pick_step());
      end
      s_tvalid <= 1'b0;
      steady   <= 1'b0;
      settle();
    end
    if (sb.mismatches == 0 && sb.expected_tones.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tso_pkg.sv
hw/rtl/tso_phase_acc.sv
hw/rtl/tso_sine_lut.sv
hw/rtl/triggered_sine_oscillator.sv
dv/tb_triggered_sine_oscillator.sv
